/* rtl/substring_first_match_finder_top_macros.svh */
`ifndef SUBSTRING_FIRST_MATCH_FINDER_TOP_MACROS_SVH
`define SUBSTRING_FIRST_MATCH_FINDER_TOP_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define SFMF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sfmf check failed");

// Antecedent holds -> consequent holds in the next cycle.
`define SFMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sfmf check failed");

`endif

/* rtl/sfmf_pkg.sv */
package sfmf_pkg;

    localparam int MAX_NEEDLE_DEF    = 16;
    localparam int POSITION_BITS_DEF = 16;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 5;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int POS_OUT_W  = 16;

    localparam logic [LEN_W-1:0] NEEDLE_LEN_RST = LEN_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEEDLE_LENGTH = 2'd0,
        CFG_NEEDLE_LOW    = 2'd1,
        CFG_NEEDLE_HIGH   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [LEN_W-1:0]      len;
        logic [CFG_DATA_W-1:0] bytes_high;
        logic [CFG_DATA_W-1:0] bytes_low;
    } t_needle_cfg;

    typedef struct packed {
        logic                 found;
        logic [POS_OUT_W-1:0] position;
        logic                 overflow;
    } t_result;

endpackage

/* rtl/sfmf_cfg.sv */
module sfmf_cfg
    import sfmf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_needle_cfg           o_cfg
);

    t_needle_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.len        <= NEEDLE_LEN_RST;
            r_cfg.bytes_low  <= '0;
            r_cfg.bytes_high <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_NEEDLE_LENGTH: r_cfg.len        <= i_cfg_wdata[LEN_W-1:0];
                CFG_NEEDLE_LOW:    r_cfg.bytes_low  <= i_cfg_wdata;
                CFG_NEEDLE_HIGH:   r_cfg.bytes_high <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/sfmf_scan.sv */
module sfmf_scan
    import sfmf_pkg::*;
#(
    parameter int MAX_NEEDLE    = MAX_NEEDLE_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    input  t_needle_cfg       i_cfg,
    output t_result           o_result
);

    localparam int CNT_W = POSITION_BITS + 1;

    logic [BYTE_W-1:0]          r_win [MAX_NEEDLE];
    logic [CNT_W-1:0]           r_seen;
    logic                       r_match;
    logic [POSITION_BITS-1:0]   r_first;
    logic                       r_ovf;

    logic [BYTE_W-1:0]          n_win [MAX_NEEDLE];
    logic [CNT_W-1:0]           n_seen;
    logic                       n_match;
    logic [POSITION_BITS-1:0]   n_first;
    logic                       n_ovf;

    logic [2*CFG_DATA_W-1:0]    needle;
    logic [MAX_NEEDLE-1:0]      hit;
    logic                       len_hit;
    logic [CNT_W-1:0]           seen_inc;
    logic                       at_limit;
    logic                       take;
    logic [POSITION_BITS+POS_OUT_W-1:0] first_ext;

    assign needle = {i_cfg.bytes_high, i_cfg.bytes_low};

    always_comb begin
        n_win[0] = i_byte;
        for (int i = 1; i < MAX_NEEDLE; i++) begin
            n_win[i] = r_win[i-1];
        end
    end

    // hit[L-1]: needle of length L ends at the newest byte
    always_comb begin
        for (int l = 1; l <= MAX_NEEDLE; l++) begin
            hit[l-1] = 1'b1;
            for (int j = 0; j < l; j++) begin
                if (n_win[l-1-j] != needle[BYTE_W*j +: BYTE_W]) begin
                    hit[l-1] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        len_hit = 1'b0;
        for (int l = 1; l <= MAX_NEEDLE; l++) begin
            if (i_cfg.len == LEN_W'(l)) begin
                len_hit = hit[l-1];
            end
        end
    end

    assign at_limit = r_seen[POSITION_BITS];
    assign seen_inc = r_seen + CNT_W'(1);
    assign take     = !at_limit && !r_match && len_hit
                      && (seen_inc >= CNT_W'(i_cfg.len));

    always_comb begin
        n_seen  = at_limit ? r_seen : seen_inc;
        n_ovf   = r_ovf | at_limit;
        n_match = r_match | take;
        n_first = take ? POSITION_BITS'(seen_inc - CNT_W'(i_cfg.len)) : r_first;
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            for (int i = 0; i < MAX_NEEDLE; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_match <= 1'b0;
            r_first <= '0;
            r_ovf   <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_seen  <= '0;
                r_match <= 1'b0;
                r_first <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_seen  <= n_seen;
                r_match <= n_match;
                r_first <= n_first;
                r_ovf   <= n_ovf;
            end
        end
    end

    assign first_ext = {{POS_OUT_W{1'b0}}, n_first};

    always_comb begin
        o_result.overflow = n_ovf;
        if (i_cfg.len == '0) begin
            o_result.found    = 1'b1;
            o_result.position = '0;
        end else begin
            o_result.found    = n_match;
            o_result.position = n_match ? first_ext[POS_OUT_W-1:0] : '0;
        end
    end

endmodule

/* rtl/substring_first_match_finder_top.sv */
// Channel  | Handshake           | Payload
// ---------+---------------------+-------------------------------------------------
// input    | i_valid / o_stall   | i_haystack_byte, i_last_byte
// output   | o_valid / i_stall   | o_found, o_match_position, o_length_overflow
// config   | i_cfg_wr_en         | i_cfg_index, i_cfg_wdata
//
// One byte per cycle sustained while no last byte waits on a stalled result: input register,
// then window compare into the result register. The result is valid once the last byte of a
// haystack leaves the input register, which holds it while the previous result is stalled.
// Synchronous active-low reset clears handshake and per-haystack state; needle length resets to 1.
// A stalled result blocks only a last byte; other bytes keep flowing.
`include "substring_first_match_finder_top_macros.svh"

module substring_first_match_finder_top
    import sfmf_pkg::*;
#(
    parameter int MAX_NEEDLE    = MAX_NEEDLE_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [BYTE_W-1:0]     i_haystack_byte,
    input  logic                  i_last_byte,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_found,
    output logic [POS_OUT_W-1:0]  o_match_position,
    output logic                  o_length_overflow,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_needle_cfg       cfg;
    t_result           scan_result;

    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_last;
    logic              r_o_valid;
    t_result           r_result;

    logic              out_free;
    logic              s1_adv;
    logic              in_acc;

    sfmf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    sfmf_scan #(
        .MAX_NEEDLE    (MAX_NEEDLE),
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_adv),
        .i_byte   (r_s1_byte),
        .i_last   (r_s1_last),
        .i_cfg    (cfg),
        .o_result (scan_result)
    );

    assign out_free = !r_o_valid || !i_stall;
    assign s1_adv   = r_s1_valid && (!r_s1_last || out_free);
    assign o_stall  = r_s1_valid && !s1_adv;
    assign in_acc   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_byte <= i_haystack_byte;
            r_s1_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv && r_s1_last) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_last) begin
            r_result <= scan_result;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_found           = r_result.found;
    assign o_match_position  = r_result.position;
    assign o_length_overflow = r_result.overflow;

    `SFMF_ASSERT_SAME(a_mid_byte_never_stalls, i_clk, i_rst_n, r_s1_valid && !r_s1_last, !o_stall)
    `SFMF_ASSERT_SAME(a_last_blocked_by_result, i_clk, i_rst_n, r_s1_valid && r_s1_last && r_o_valid && i_stall, o_stall)
    `SFMF_ASSERT_NEXT(a_last_makes_result, i_clk, i_rst_n, s1_adv && r_s1_last, o_valid)
    `SFMF_ASSERT_SAME(a_no_position_if_absent, i_clk, i_rst_n, o_valid && !o_found, o_match_position == '0)

endmodule

/* tb/first_match_monitor.sv */
module first_match_monitor
    import sfmf_pkg::*;
#(
    parameter int MAX_NEEDLE    = MAX_NEEDLE_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [BYTE_W-1:0]     i_byte,
    input  logic                  i_last,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_found,
    input  logic [POS_OUT_W-1:0]  i_position,
    input  logic                  i_overflow,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_outstanding,
    output int                    o_results,
    output int                    o_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [POSITION_BITS:0] POS_LIMIT = {1'b1, {POSITION_BITS{1'b0}}};

    logic [LEN_W-1:0]      needle_len;
    logic [CFG_DATA_W-1:0] needle_lo;
    logic [CFG_DATA_W-1:0] needle_hi;

    logic [BYTE_W-1:0]     window [MAX_NEEDLE];
    logic [POSITION_BITS:0] bytes_seen;
    logic                  match_seen;
    logic [POS_OUT_W-1:0]  match_start;
    logic                  overflow_seen;

    t_result expected_results [$];
    int fails = 0;
    int results = 0;
    int hits = 0;

    function automatic logic [BYTE_W-1:0] needle_byte(int j);
        return (j < 8) ? needle_lo[j*BYTE_W +: BYTE_W] : needle_hi[(j-8)*BYTE_W +: BYTE_W];
    endfunction

    function automatic bit needle_ends_here(int len);
        for (int j = 0; j < len; j++) begin
            if (window[len-1-j] != needle_byte(j)) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    task automatic clear_haystack();
        foreach (window[k]) window[k] = '0;
        bytes_seen    = '0;
        match_seen    = 1'b0;
        match_start   = '0;
        overflow_seen = 1'b0;
    endtask

    task automatic scan_byte(logic [BYTE_W-1:0] b, logic last);
        logic [POSITION_BITS:0] offset;
        int len;
        t_result res;
        offset = bytes_seen;
        len = int'(needle_len);
        for (int k = MAX_NEEDLE - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = b;
        if (offset >= POS_LIMIT) begin
            overflow_seen = 1'b1;
        end else begin
            bytes_seen = offset + 1'b1;
            if (!match_seen && len >= 1 && len <= MAX_NEEDLE && offset + 1 >= len &&
                needle_ends_here(len)) begin
                match_seen  = 1'b1;
                match_start = POS_OUT_W'(offset + 1 - len);
            end
        end
        if (last) begin
            if (len == 0) begin
                res.found    = 1'b1;
                res.position = '0;
            end else begin
                res.found    = match_seen;
                res.position = match_seen ? match_start : '0;
            end
            res.overflow = overflow_seen;
            expected_results.push_back(res);
            clear_haystack();
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            needle_len = NEEDLE_LEN_RST;
            needle_lo  = '0;
            needle_hi  = '0;
            clear_haystack();
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (i_found === 1'b1) hits++;
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing outstanding");
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("found", 32'(want.found), 32'(i_found));
                    check_field("match_position", 32'(want.position), 32'(i_position));
                    check_field("length_overflow", 32'(want.overflow), 32'(i_overflow));
                end
            end
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_NEEDLE_LENGTH: needle_len = i_cfg_wdata[LEN_W-1:0];
                    CFG_NEEDLE_LOW:    needle_lo  = i_cfg_wdata;
                    CFG_NEEDLE_HIGH:   needle_hi  = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) scan_byte(i_byte, i_last);
        end
        o_fail_count  <= fails;
        o_outstanding <= expected_results.size();
        o_results     <= results;
        o_hits        <= hits;
    end

endmodule

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfmf_pkg::*;

    localparam int RANDOM_BYTES = 750;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [BYTE_W-1:0]     i_haystack_byte = '0;
    logic                  i_last_byte = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_found;
    logic [POS_OUT_W-1:0]  o_match_position;
    logic                  o_length_overflow;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    int fail_count;
    int outstanding;
    int results_checked;
    int hits;

    bit quiet = 1'b0;
    int gap_pct = 0;
    int bytes_sent = 0;
    int haystacks_sent = 0;
    int settings_used = 0;

    logic [LEN_W-1:0]      needle_len = NEEDLE_LEN_RST;
    logic [CFG_DATA_W-1:0] needle_lo = '0;
    logic [CFG_DATA_W-1:0] needle_hi = '0;
    logic [BYTE_W-1:0]     text [$];

    substring_first_match_finder_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_haystack_byte   (i_haystack_byte),
        .i_last_byte       (i_last_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_found           (o_found),
        .o_match_position  (o_match_position),
        .o_length_overflow (o_length_overflow),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    first_match_monitor monitor_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_byte        (i_haystack_byte),
        .i_last        (i_last_byte),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_found       (o_found),
        .i_position    (o_match_position),
        .i_overflow    (o_length_overflow),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_results     (results_checked),
        .o_hits        (hits)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [BYTE_W-1:0] needle_at(int j);
        return (j < 8) ? needle_lo[j*BYTE_W +: BYTE_W] : needle_hi[(j-8)*BYTE_W +: BYTE_W];
    endfunction

    task automatic push_byte(logic [BYTE_W-1:0] b, logic last);
        i_valid         <= 1'b1;
        i_haystack_byte <= b;
        i_last_byte     <= last;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic send_bytes(logic [BYTE_W-1:0] hay [$]);
        foreach (hay[k]) push_byte(hay[k], k == hay.size() - 1);
        haystacks_sent++;
    endtask

    // hold off until every result is back, then let the pipeline empty
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_needle(logic [LEN_W-1:0] len, logic [CFG_DATA_W-1:0] lo,
                              logic [CFG_DATA_W-1:0] hi);
        logic [CFG_DATA_W-1:0] w;
        w = {$urandom(), $urandom()};
        w[LEN_W-1:0] = len;
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_NEEDLE_LENGTH;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_index <= CFG_NEEDLE_LOW;
        i_cfg_wdata <= lo;
        @(posedge i_clk);
        i_cfg_index <= CFG_NEEDLE_HIGH;
        i_cfg_wdata <= hi;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        needle_len = len;
        needle_lo  = lo;
        needle_hi  = hi;
        settings_used++;
    endtask

    task automatic random_needle();
        logic [LEN_W-1:0]      len;
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [BYTE_W-1:0]     alpha [4] = '{8'h00, 8'hFF, 8'h5A, 8'h5B};
        case ($urandom_range(0, 9))
            0:       len = '0;
            1:       len = LEN_W'(16);
            2:       len = LEN_W'($urandom_range(17, 31));
            3:       len = LEN_W'(1);
            default: len = LEN_W'($urandom_range(1, $urandom_range(0, 1) ? 4 : 16));
        endcase
        case ($urandom_range(0, 5))
            0: begin
                lo = '0;
                hi = '0;
            end
            1: begin
                lo = '1;
                hi = '1;
            end
            2, 3: begin
                lo = {$urandom(), $urandom()};
                hi = {$urandom(), $urandom()};
            end
            default: begin
                for (int b = 0; b < 8; b++) begin
                    lo[b*BYTE_W +: BYTE_W] = alpha[$urandom_range(0, 3)];
                    hi[b*BYTE_W +: BYTE_W] = alpha[$urandom_range(0, 3)];
                end
            end
        endcase
        set_needle(len, lo, hi);
    endtask

    task automatic send_haystack();
        int n;
        int mode;
        int at;
        logic [BYTE_W-1:0] hay [$];
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
        mode = $urandom_range(0, 2);
        for (int k = 0; k < n; k++) begin
            case (mode)
                0:       hay.push_back(BYTE_W'($urandom_range(0, 255)));
                1:       hay.push_back(needle_at($urandom_range(0, 15)));
                default: hay.push_back($urandom_range(0, 1) ? needle_at(0) : 8'h5A);
            endcase
        end
        // plant whole or clipped copies of the needle
        repeat ($urandom_range(0, 2)) begin
            at = $urandom_range(0, n - 1);
            for (int j = 0; j < needle_len && j < 16 && at + j < n; j++) hay[at+j] = needle_at(j);
        end
        send_bytes(hay);
    endtask

    initial begin
        int random_start;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset needle is one zero byte
        text = '{8'h41, 8'h00, 8'hFF};
        send_bytes(text);
        drain();
        set_needle('0, '1, '1);
        text = '{8'hFF};
        send_bytes(text);
        drain();
        set_needle(LEN_W'(17), '1, '1);
        text = '{8'h00};
        send_bytes(text);
        drain();
        set_needle(LEN_W'(16), '1, '1);
        text = {};
        repeat (16) text.push_back(8'hFF);
        send_bytes(text);
        drain();
        set_needle(LEN_W'(2), 64'h00FF, '0);
        text = '{8'hFF};
        send_bytes(text);

        drain();
        set_needle(LEN_W'(4), 64'h0403_0201, '0);
        text = '{8'hAA, 8'h01, 8'h02, 8'h03, 8'h04};
        send_bytes(text);

        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            drain();
            random_needle();
            repeat ($urandom_range(4, 10)) begin
                if (bytes_sent - random_start >= RANDOM_BYTES - 100) quiet = 1'b1;
                gap_pct = $urandom_range(0, 2) * 25;
                send_haystack();
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        $display("Sent %0d haystacks (%0d bytes) under %0d needle settings.",
                 haystacks_sent, bytes_sent, settings_used);
        $display("Checked %0d results, %0d of them reporting a match.", results_checked, hits);
        if (fail_count == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        int p;
        repeat (12) @(posedge i_clk);
        forever begin
            p = $urandom_range(0, 2) * 20;
            repeat ($urandom_range(20, 80)) begin
                @(posedge i_clk);
                if (!quiet && $urandom_range(0, 99) < p) begin
                    i_stall <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
        end
    end

endmodule
